// ----- rtl/core/ttb_pkg.sv -----
`default_nettype none
package ttb_pkg;

  localparam int POS_W     = 24;
  localparam int UV_W      = 16;
  localparam int OUT_W     = 16;
  localparam int OUT_FRAC  = OUT_W - 2;
  localparam int NORM_BITS = 30;

  localparam int DPOS_W = POS_W + 1;
  localparam int DUV_W  = UV_W + 1;
  localparam int VEC_W  = DPOS_W + DUV_W + 1;
  localparam int MUL_W  = (DPOS_W > NORM_BITS + 2) ? DPOS_W : NORM_BITS + 2;
  localparam int SUM_W  = 2 * NORM_BITS + 2;
  localparam int LEN_W  = NORM_BITS + 1;
  localparam int NUM_W  = NORM_BITS + 1 + OUT_FRAC;

  localparam logic signed [OUT_W-1:0] UNIT = OUT_W'(1) <<< OUT_FRAC;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [UV_W-1:0]         tex_u;
    logic [UV_W-1:0]         tex_v;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] tangent_x;
    logic signed [OUT_W-1:0] tangent_y;
    logic signed [OUT_W-1:0] tangent_z;
    logic signed [OUT_W-1:0] bitangent_x;
    logic signed [OUT_W-1:0] bitangent_y;
    logic signed [OUT_W-1:0] bitangent_z;
    logic                    degenerate;
  } out_t;

endpackage
`default_nettype wire

// ----- rtl/core/ttb_mul.sv -----
`default_nettype none
module ttb_mul #(
  parameter int W = 32
) (
  input  wire logic                  clk,
  input  wire logic signed [W-1:0]   a,
  input  wire logic signed [W-1:0]   b,
  output logic signed [2*W-1:0]      p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

// ----- rtl/core/ttb_isqrt.sv -----
`default_nettype none
module ttb_isqrt #(
  parameter int SW = 62
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [SW-1:0]   radicand,
  output logic                 done,
  output logic [SW/2-1:0]      root
);

  localparam int ITER = SW / 2;
  localparam int CW   = $clog2(ITER + 1);

  logic [SW-1:0] s;
  logic [SW-1:0] res;
  logic [SW-1:0] bitv;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [SW-1:0] trial;

  assign trial = res + bitv;
  assign root  = res[SW/2-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        s    <= radicand;
        res  <= '0;
        bitv <= SW'(1) << (SW - 2);
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (s >= trial) begin
          s   <= s - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + CW'(1);
        if (cnt == CW'(ITER - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/ttb_div.sv -----
`default_nettype none
module ttb_div #(
  parameter int NW = 45,
  parameter int DW = 31
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [NW-1:0]   dividend,
  input  wire logic [DW-1:0]   divisor,
  output logic                 done,
  output logic [NW-1:0]        quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num;
  logic [DW-1:0] den;
  logic [DW-1:0] rem;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;
  logic          qbit;

  // Restoring long division: one quotient bit a cycle, shifted into num.
  assign trial    = {rem, num[NW-1]};
  assign qbit     = (trial >= {1'b0, den});
  assign quotient = num;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        num  <= dividend;
        den  <= divisor;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (qbit) begin
          rem <= DW'(trial - {1'b0, den});
        end else begin
          rem <= trial[DW-1:0];
        end
        num <= {num[NW-2:0], qbit};
        cnt <= cnt + CW'(1);
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/triangle_tangent_basis_top.sv -----
// The first two vertices of a triangle are stored and give no result. After the third vertex
// the block runs the products, per vector the normalising shifts, the squares and root and
// three divisions, and then loads the result register. A zero determinant is found after the
// products, a zero tangent or bitangent while its vector is normalised, and gives the result
// early; a result not yet transferred adds its wait. No vertex is taken until the result
// register is loaded. Reset (rst, synchronous): phase to first, no result.
`default_nettype none
module triangle_tangent_basis_top import ttb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_MUL    = 9'b000000010,
    S_NSHIFT = 9'b000000100,
    S_SQR    = 9'b000001000,
    S_SQST   = 9'b000010000,
    S_SQRT   = 9'b000100000,
    S_DVST   = 9'b001000000,
    S_DIV    = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state;
  logic [1:0] phase;
  in_t v1, v2, v3;
  logic [3:0] cnt;
  logic [3:0] pidx;
  logic vsel;
  logic deg;
  logic signed [VEC_W-1:0] vec [7];
  logic signed [VEC_W-1:0] hold;
  logic [VEC_W-1:0] mag [3];
  logic sgn [3];
  logic [SUM_W-1:0] sum;
  logic [LEN_W-1:0] len;
  logic signed [OUT_W-1:0] res [6];

  logic signed [DUV_W-1:0] du1, dv1, du2, dv2;
  logic signed [DPOS_W-1:0] e1 [3];
  logic signed [DPOS_W-1:0] e2 [3];
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [2*MUL_W-1:0] prod;
  logic [VEC_W-1:0] or_m;

  logic sqrt_start, sqrt_done;
  logic [SUM_W/2-1:0] sqrt_root;
  logic div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quot;
  logic [OUT_W-1:0] qmag;

  assign in_ready = (state == S_IDLE);

  assign du1 = $signed({1'b0, v2.tex_u}) - $signed({1'b0, v1.tex_u});
  assign dv1 = $signed({1'b0, v2.tex_v}) - $signed({1'b0, v1.tex_v});
  assign du2 = $signed({1'b0, v3.tex_u}) - $signed({1'b0, v1.tex_u});
  assign dv2 = $signed({1'b0, v3.tex_v}) - $signed({1'b0, v1.tex_v});

  assign e1[0] = DPOS_W'(v2.pos_x) - DPOS_W'(v1.pos_x);
  assign e1[1] = DPOS_W'(v2.pos_y) - DPOS_W'(v1.pos_y);
  assign e1[2] = DPOS_W'(v2.pos_z) - DPOS_W'(v1.pos_z);
  assign e2[0] = DPOS_W'(v3.pos_x) - DPOS_W'(v1.pos_x);
  assign e2[1] = DPOS_W'(v3.pos_y) - DPOS_W'(v1.pos_y);
  assign e2[2] = DPOS_W'(v3.pos_z) - DPOS_W'(v1.pos_z);

  assign pidx = cnt - 4'd1;
  assign or_m = mag[0] | mag[1] | mag[2];

  // Products are issued in pairs in S_MUL, the second subtracted from the first; S_SQR squares.
  always_comb begin
    mul_a = MUL_W'(du1);
    mul_b = MUL_W'(dv2);
    if (state == S_SQR) begin
      mul_a = $signed(MUL_W'(mag[0][NORM_BITS:0]));
      mul_b = $signed(MUL_W'(mag[0][NORM_BITS:0]));
    end else begin
      case (cnt)
        4'd0:  begin mul_a = MUL_W'(du1); mul_b = MUL_W'(dv2);   end
        4'd1:  begin mul_a = MUL_W'(du2); mul_b = MUL_W'(dv1);   end
        4'd2:  begin mul_a = MUL_W'(dv2); mul_b = MUL_W'(e1[0]); end
        4'd3:  begin mul_a = MUL_W'(dv1); mul_b = MUL_W'(e2[0]); end
        4'd4:  begin mul_a = MUL_W'(dv2); mul_b = MUL_W'(e1[1]); end
        4'd5:  begin mul_a = MUL_W'(dv1); mul_b = MUL_W'(e2[1]); end
        4'd6:  begin mul_a = MUL_W'(dv2); mul_b = MUL_W'(e1[2]); end
        4'd7:  begin mul_a = MUL_W'(dv1); mul_b = MUL_W'(e2[2]); end
        4'd8:  begin mul_a = MUL_W'(du1); mul_b = MUL_W'(e2[0]); end
        4'd9:  begin mul_a = MUL_W'(du2); mul_b = MUL_W'(e1[0]); end
        4'd10: begin mul_a = MUL_W'(du1); mul_b = MUL_W'(e2[1]); end
        4'd11: begin mul_a = MUL_W'(du2); mul_b = MUL_W'(e1[1]); end
        4'd12: begin mul_a = MUL_W'(du1); mul_b = MUL_W'(e2[2]); end
        4'd13: begin mul_a = MUL_W'(du2); mul_b = MUL_W'(e1[2]); end
        default: begin mul_a = MUL_W'(du1); mul_b = MUL_W'(dv2); end
      endcase
    end
  end

  ttb_mul #(.W(MUL_W)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign sqrt_start = (state == S_SQST);

  ttb_isqrt #(.SW(SUM_W)) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sum),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  assign div_start = (state == S_DVST);
  assign div_num   = (NUM_W'(mag[0][NORM_BITS:0]) << OUT_FRAC) + NUM_W'(len >> 1);

  ttb_div #(.NW(NUM_W), .DW(LEN_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (len),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign qmag = div_quot[OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (phase)
              2'd0: begin
                v1    <= in_data;
                phase <= 2'd1;
              end
              2'd1: begin
                v2    <= in_data;
                phase <= 2'd2;
              end
              default: begin
                v3    <= in_data;
                phase <= 2'd0;
                cnt   <= '0;
                vsel  <= 1'b0;
                deg   <= 1'b0;
                state <= S_MUL;
              end
            endcase
          end
        end
        S_MUL: begin
          if (cnt != 4'd0) begin
            if (!pidx[0]) begin
              hold <= $signed(prod[VEC_W-1:0]);
            end else begin
              vec[pidx[3:1]] <= hold - $signed(prod[VEC_W-1:0]);
            end
          end
          cnt <= cnt + 4'd1;
          if (cnt == 4'd14) begin
            if (vec[0] == '0) begin
              deg   <= 1'b1;
              state <= S_DONE;
            end else begin
              for (int i = 0; i < 3; i++) begin
                mag[i] <= vec[1+i][VEC_W-1] ? VEC_W'(-vec[1+i]) : VEC_W'(vec[1+i]);
                sgn[i] <= vec[1+i][VEC_W-1] ^ vec[0][VEC_W-1];
              end
              state <= S_NSHIFT;
            end
          end
        end
        S_NSHIFT: begin
          // Single-bit shifts until the largest magnitude is exactly NORM_BITS long.
          if (or_m == '0) begin
            deg   <= 1'b1;
            state <= S_DONE;
          end else if (or_m[VEC_W-1:NORM_BITS] != '0) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
          end else if (!or_m[NORM_BITS-1]) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
          end else begin
            cnt   <= '0;
            sum   <= '0;
            state <= S_SQR;
          end
        end
        S_SQR: begin
          if (cnt < 4'd3) begin
            mag[0] <= mag[1];
            mag[1] <= mag[2];
            mag[2] <= mag[0];
          end
          if (cnt != 4'd0) begin
            sum <= sum + prod[SUM_W-1:0];
          end
          cnt <= cnt + 4'd1;
          if (cnt == 4'd3) begin
            state <= S_SQST;
          end
        end
        S_SQST: begin
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (sqrt_done) begin
            len   <= sqrt_root;
            cnt   <= '0;
            state <= S_DVST;
          end
        end
        S_DVST: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            for (int i = 0; i < 5; i++) res[i] <= res[i+1];
            res[5] <= sgn[0] ? -$signed(qmag) : $signed(qmag);
            cnt    <= cnt + 4'd1;
            if (cnt == 4'd2 && !vsel) begin
              vsel <= 1'b1;
              for (int i = 0; i < 3; i++) begin
                mag[i] <= vec[4+i][VEC_W-1] ? VEC_W'(-vec[4+i]) : VEC_W'(vec[4+i]);
                sgn[i] <= vec[4+i][VEC_W-1] ^ vec[0][VEC_W-1];
              end
              state <= S_NSHIFT;
            end else begin
              mag[0] <= mag[1];
              mag[1] <= mag[2];
              mag[2] <= mag[0];
              sgn[0] <= sgn[1];
              sgn[1] <= sgn[2];
              sgn[2] <= sgn[0];
              if (cnt == 4'd2) begin
                state <= S_DONE;
              end else begin
                state <= S_DVST;
              end
            end
          end
        end
        S_DONE: begin
          // The result register frees up in the same cycle it is transferred.
          if (!out_valid || out_ready) begin
            out_valid             <= 1'b1;
            out_data.degenerate   <= deg;
            out_data.tangent_x    <= deg ? '0 : res[0];
            out_data.tangent_y    <= deg ? '0 : res[1];
            out_data.tangent_z    <= deg ? '0 : res[2];
            out_data.bitangent_x  <= deg ? '0 : res[3];
            out_data.bitangent_y  <= deg ? '0 : res[4];
            out_data.bitangent_z  <= deg ? '0 : res[5];
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.degenerate |->
      out_data.tangent_x == '0 && out_data.tangent_y == '0 && out_data.tangent_z == '0 &&
      out_data.bitangent_x == '0 && out_data.bitangent_y == '0 &&
      out_data.bitangent_z == '0)
    else $error("degenerate result carries a non-zero vector");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.degenerate |->
      out_data.tangent_x <= UNIT && out_data.tangent_x >= -UNIT &&
      out_data.bitangent_z <= UNIT && out_data.bitangent_z >= -UNIT)
    else $error("normalised component exceeds one");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase != 2'd3)
    else $error("vertex phase out of range");

  a_result_from_third: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_MUL) |-> phase == 2'd0)
    else $error("triangle started without the phase returning to the first vertex");

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
module tb_top;
  import ttb_pkg::*;

  typedef longint signed      comp3_t [3];
  typedef logic [OUT_W-1:0]   unit3_t [3];

  typedef struct {
    in_t  vtx;
    bit   typed;
    out_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  triangle_tangent_basis_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #10 clk = ~clk;

  // Predictor state: the two stored vertices and the vertex phase.
  in_t      corner_a, corner_b;
  bit [1:0] corner_phase;

  out_t     basis_q[$];
  int       n_in_taken = 0;
  int       n_basis_seen = 0;
  int       n_degenerate = 0;
  int       n_errors = 0;
  int       hold_request = 0;

  stim_row_t rows[$];

  function automatic longint unsigned root_floor(input longint unsigned s);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic bit to_unit(input comp3_t c, output unit3_t q);
    longint unsigned m[3], mx, s, len, d;
    int b;
    mx = 0;
    s = 0;
    b = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (c[i] < 0) ? longint'(-c[i]) : longint'(c[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return 1'b0;
    while (b < 64 && (mx >> b) != 0) b++;
    for (int i = 0; i < 3; i++) begin
      if (b > NORM_BITS) m[i] = m[i] >> (b - NORM_BITS);
      else m[i] = m[i] << (NORM_BITS - b);
      s = s + m[i] * m[i];
    end
    len = root_floor(s);
    for (int i = 0; i < 3; i++) begin
      d = ((m[i] << OUT_FRAC) + (len >> 1)) / len;
      q[i] = (c[i] < 0) ? OUT_W'(-d) : OUT_W'(d);
    end
    return 1'b1;
  endfunction

  function automatic bit predict_basis(input in_t v, output out_t r);
    longint signed du1, dv1, du2, dv2, det, e1, e2;
    comp3_t t, bt;
    longint signed pa[3], pb[3], pc[3];
    unit3_t tq, bq;
    r = '0;
    if (corner_phase == 2'd0) begin
      corner_a = v;
      corner_phase = 2'd1;
      return 1'b0;
    end
    if (corner_phase == 2'd1) begin
      corner_b = v;
      corner_phase = 2'd2;
      return 1'b0;
    end
    corner_phase = 2'd0;
    du1 = longint'(corner_b.tex_u) - longint'(corner_a.tex_u);
    dv1 = longint'(corner_b.tex_v) - longint'(corner_a.tex_v);
    du2 = longint'(v.tex_u) - longint'(corner_a.tex_u);
    dv2 = longint'(v.tex_v) - longint'(corner_a.tex_v);
    det = du1 * dv2 - du2 * dv1;
    pa[0] = longint'(corner_a.pos_x); pa[1] = longint'(corner_a.pos_y);
    pa[2] = longint'(corner_a.pos_z);
    pb[0] = longint'(corner_b.pos_x); pb[1] = longint'(corner_b.pos_y);
    pb[2] = longint'(corner_b.pos_z);
    pc[0] = longint'(v.pos_x); pc[1] = longint'(v.pos_y); pc[2] = longint'(v.pos_z);
    for (int i = 0; i < 3; i++) begin
      e1 = pb[i] - pa[i];
      e2 = pc[i] - pa[i];
      t[i] = dv2 * e1 - dv1 * e2;
      bt[i] = du1 * e2 - du2 * e1;
      if (det < 0) begin
        t[i] = -t[i];
        bt[i] = -bt[i];
      end
    end
    if (det == 0 || !to_unit(t, tq) || !to_unit(bt, bq)) begin
      r.degenerate = 1'b1;
      return 1'b1;
    end
    r.tangent_x = tq[0];   r.tangent_y = tq[1];   r.tangent_z = tq[2];
    r.bitangent_x = bq[0]; r.bitangent_y = bq[1]; r.bitangent_z = bq[2];
    return 1'b1;
  endfunction

  task automatic report_fault(input string msg);
    $display("MISMATCH %s", msg);
    n_errors++;
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    report_fault($sformatf("result %0d %s: got %0d expected %0d",
                           n_basis_seen, what, got, want));
  endtask

  task automatic compare_basis(input out_t got, input out_t want);
    if (got.tangent_x !== want.tangent_x)
      report_mismatch("tangent_x", longint'(got.tangent_x), longint'(want.tangent_x));
    if (got.tangent_y !== want.tangent_y)
      report_mismatch("tangent_y", longint'(got.tangent_y), longint'(want.tangent_y));
    if (got.tangent_z !== want.tangent_z)
      report_mismatch("tangent_z", longint'(got.tangent_z), longint'(want.tangent_z));
    if (got.bitangent_x !== want.bitangent_x)
      report_mismatch("bitangent_x", longint'(got.bitangent_x), longint'(want.bitangent_x));
    if (got.bitangent_y !== want.bitangent_y)
      report_mismatch("bitangent_y", longint'(got.bitangent_y), longint'(want.bitangent_y));
    if (got.bitangent_z !== want.bitangent_z)
      report_mismatch("bitangent_z", longint'(got.bitangent_z), longint'(want.bitangent_z));
    if (got.degenerate !== want.degenerate)
      report_mismatch("degenerate", longint'(got.degenerate), longint'(want.degenerate));
  endtask

  // Both transfers are observed here at the rising edge.
  always @(posedge clk) begin
    out_t pred;
    out_t want;
    if (!rst && in_valid && in_ready) begin
      if (predict_basis(in_data, pred)) basis_q.insert(basis_q.size(), pred);
      n_in_taken <= n_in_taken + 1;
    end
    if (!rst && out_valid && out_ready) begin
      if (basis_q.size() == 0) begin
        report_fault($sformatf("unexpected result %0d", n_basis_seen));
      end else begin
        want = basis_q.pop_front();
        compare_basis(out_data, want);
      end
      if (out_data.degenerate) n_degenerate++;
      n_basis_seen++;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // Holds the valid until the transfer is seen, then, for a nonzero gap, drops it and idles.
  task automatic offer_vertex(input in_t v, input int gap);
    int start;
    start = n_in_taken;
    in_valid <= 1'b1;
    in_data <= v;
    do @(negedge clk); while (n_in_taken == start);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic in_t rand_vertex(input int uv_mode);
    in_t v;
    v.pos_x = POS_W'($urandom);
    v.pos_y = POS_W'($urandom);
    v.pos_z = POS_W'($urandom);
    case (uv_mode)
      0: begin v.tex_u = UV_W'($urandom); v.tex_v = UV_W'($urandom); end
      1: begin
        v.tex_u = UV_W'($urandom_range(1000, 1010));
        v.tex_v = UV_W'($urandom_range(500, 503));
      end
      default: begin v.tex_u = 16'd4660; v.tex_v = 16'd22136; end
    endcase
    if ($urandom_range(0, 9) == 0) begin
      v.pos_x = POS_W'($urandom_range(0, 7));
      v.pos_y = POS_W'(-$urandom_range(0, 7));
    end
    return v;
  endfunction

  function automatic in_t mk(input int x, input int y, input int z, input int u, input int w);
    in_t v;
    v.pos_x = POS_W'(x); v.pos_y = POS_W'(y); v.pos_z = POS_W'(z);
    v.tex_u = UV_W'(u); v.tex_v = UV_W'(w);
    return v;
  endfunction

  task automatic add_row(input in_t v, input bit typed, input out_t want);
    stim_row_t r;
    r.vtx = v;
    r.typed = typed;
    r.want = want;
    rows.insert(rows.size(), r);
  endtask

  // Receiver: random ready, occasional long stalls, and one requested hold.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold = hold_request;
        hold_request = 0;
      end else if (hold == 0 && $urandom_range(0, 999) == 0) begin
        hold = $urandom_range(50, 300);
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= ($urandom_range(0, 9) < 7);
      end
    end
  end

  initial begin
    out_t none, tx_by, ty_bx, degen;
    int mode, n_rand, gap;
    bit held, drained;
    none = '0;
    tx_by = '0; tx_by.tangent_x = UNIT; tx_by.bitangent_y = UNIT;
    ty_bx = '0; ty_bx.tangent_y = UNIT; ty_bx.bitangent_x = UNIT;
    degen = '0; degen.degenerate = 1'b1;
    held = 1'b0;
    drained = 1'b0;

    // Axis-aligned triangle, positive determinant.
    add_row(mk(0, 0, 0, 0, 0), 1'b0, none);
    add_row(mk(1, 0, 0, 1, 0), 1'b0, none);
    add_row(mk(0, 1, 0, 0, 1), 1'b1, tx_by);
    // Texture coordinates swapped: negative determinant flips both vectors.
    add_row(mk(0, 0, 0, 0, 0), 1'b0, none);
    add_row(mk(1, 0, 0, 0, 1), 1'b0, none);
    add_row(mk(0, 1, 0, 1, 0), 1'b1, ty_bx);
    // All uv equal: zero determinant.
    add_row(mk(5, 6, 7, 65535, 65535), 1'b0, none);
    add_row(mk(-8388608, 3, 9, 65535, 65535), 1'b0, none);
    add_row(mk(8388607, 1, 2, 65535, 65535), 1'b1, degen);
    // Coincident positions: zero tangent with a valid determinant.
    add_row(mk(-8388608, -8388608, -8388608, 0, 0), 1'b0, none);
    add_row(mk(-8388608, -8388608, -8388608, 65535, 0), 1'b0, none);
    add_row(mk(-8388608, -8388608, -8388608, 0, 65535), 1'b1, degen);
    // Position and uv extremes, then small mixed-sign values.
    add_row(mk(-8388608, -8388608, -8388608, 0, 0), 1'b0, none);
    add_row(mk(8388607, 8388607, 8388607, 65535, 0), 1'b0, none);
    add_row(mk(8388607, -8388608, 0, 0, 65535), 1'b0, none);
    add_row(mk(8388607, 8388607, 8388607, 65535, 65535), 1'b0, none);
    add_row(mk(-8388608, 0, 8388607, 0, 65535), 1'b0, none);
    add_row(mk(0, -8388608, -1, 65535, 0), 1'b0, none);
    add_row(mk(-1, -1, -1, 1, 2), 1'b0, none);
    add_row(mk(-2, 3, -4, 3, 1), 1'b0, none);
    add_row(mk(7, -5, 1, 2, 3), 1'b0, none);

    corner_a = '0;
    corner_b = '0;
    corner_phase = 2'd0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) begin
      offer_vertex(rows[i].vtx, 0);
      // A typed expectation replaces the predicted one for this result.
      if (rows[i].typed && basis_q.size() > 0) begin
        basis_q[basis_q.size() - 1] = rows[i].want;
      end
      gap = pick_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end

    n_rand = 0;
    while (n_rand < 1600) begin
      if (!held && n_rand >= 600) begin
        held = 1'b1;
        hold_request = 3000;
      end
      if (!drained && n_rand >= 1200) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        while (basis_q.size() != 0) @(negedge clk);
      end
      mode = $urandom_range(0, 9);
      if ($urandom_range(0, 19) == 0) begin
        // Stray single vertices knock the triangle framing off by one.
        offer_vertex(rand_vertex(0), pick_gap());
        n_rand++;
      end else begin
        for (int k = 0; k < 3; k++)
          offer_vertex(rand_vertex(mode < 7 ? 0 : (mode < 9 ? 1 : 2)), pick_gap());
        n_rand += 3;
      end
    end
    in_valid <= 1'b0;

    while (basis_q.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    if (basis_q.size() != 0) begin
      report_fault($sformatf("%0d expected results never arrived", basis_q.size()));
    end
    $display("Covered %0d vertices and %0d triangle results, %0d of them degenerate.",
             n_in_taken, n_basis_seen, n_degenerate);
    $display("Mismatches counted: %0d", n_errors);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(20 * 4000000);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/ttb_pkg.sv
rtl/core/ttb_mul.sv
rtl/core/ttb_isqrt.sv
rtl/core/ttb_div.sv
rtl/core/triangle_tangent_basis_top.sv
sim/tb_top.sv
